@@ rtl/srdc_pkg.sv @@
// Shared definitions for the stick radial dead zone block.
// Register map and configuration field widths. No dependencies.
package srdc_pkg;

  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int CENTER_W = 15;
  localparam int DZ_W     = 14;

  typedef enum logic [1:0] {
    REG_REST_X    = 2'd0,
    REG_REST_Y    = 2'd1,
    REG_DEAD_ZONE = 2'd2
  } reg_idx_t;

endpackage

@@ rtl/srdc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep.
// Carries a sideband payload alongside. Standalone, no package use.
module srdc_div #(
  parameter int LANES = 2,
  parameter int NW    = 32,
  parameter int DW    = 16,
  parameter int QW    = 16,
  parameter int PW    = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [LANES-1:0][NW-1:0]    num,
  input  logic [LANES-1:0][DW-1:0]    den,
  input  logic [PW-1:0]               in_pay,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [LANES-1:0][QW-1:0]    quo,
  output logic [PW-1:0]               out_pay
);

  localparam int NST = QW + 1;

  logic [NST-1:0] vld;
  logic [NST:0]   rdy;

  logic [LANES-1:0][NW-1:0] rem [QW];
  logic [LANES-1:0][DW-1:0] dv  [QW];
  logic [LANES-1:0][QW-1:0] qq  [NST];
  logic [PW-1:0]            pay [NST];

  assign rdy[NST] = !out_stall;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (rdy[NST-1:0] & {vld[NST-2:0], in_valid}) | (~rdy[NST-1:0] & vld);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem[0] <= num;
      dv[0]  <= den;
      qq[0]  <= '0;
      pay[0] <= in_pay;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [LANES-1:0][NW-1:0] rem_next;
    logic [LANES-1:0][QW-1:0] q_next;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if ((rem[k-1][l] >> B) >= NW'(dv[k-1][l])) begin
          rem_next[l] = rem[k-1][l] - (NW'(dv[k-1][l]) << B);
          q_next[l]   = qq[k-1][l] | (QW'(1) << B);
        end else begin
          rem_next[l] = rem[k-1][l];
          q_next[l]   = qq[k-1][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        qq[k]  <= q_next;
        pay[k] <= pay[k-1];
      end
    end

    if (k < QW) begin : g_keep
      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          rem[k] <= rem_next;
          dv[k]  <= dv[k-1];
        end
      end
    end
  end

  assign out_valid = vld[NST-1];
  assign quo       = qq[NST-1];
  assign out_pay   = pay[NST-1];

endmodule

@@ rtl/srdc_sqrt.sv @@
// Pipelined radius unit: sum of squares, then one root bit per stage, then round to nearest.
// Carries a sideband payload alongside. Standalone, no package use.
module srdc_sqrt #(
  parameter int W  = 16,
  parameter int PW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [W-1:0]  ax,
  input  logic [W-1:0]  ay,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [W-1:0]  r,
  output logic [PW-1:0] out_pay
);

  localparam int RW  = 2 * W + 1;
  localparam int NST = W + 2;

  logic [NST-1:0] vld;
  logic [NST:0]   rdy;

  logic [RW-1:0] rem [W+1];
  logic [W-1:0]  q   [W+1];
  logic [PW-1:0] pay [NST];

  assign rdy[NST] = !out_stall;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (rdy[NST-1:0] & {vld[NST-2:0], in_valid}) | (~rdy[NST-1:0] & vld);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem[0] <= RW'(ax) * RW'(ax) + RW'(ay) * RW'(ay);
      q[0]   <= '0;
      pay[0] <= in_pay;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_stage
    localparam int B = W - k;
    logic [RW-1:0] trial;

    assign trial = (RW'(q[k-1]) << (B + 1)) | (RW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        if (rem[k-1] >= trial) begin
          rem[k] <= rem[k-1] - trial;
          q[k]   <= q[k-1] | (W'(1) << B);
        end else begin
          rem[k] <= rem[k-1];
          q[k]   <= q[k-1];
        end
        pay[k] <= pay[k-1];
      end
    end
  end

  // round to nearest: remainder above root means root + 1/2 is below the true value
  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      r            <= (rem[W] > RW'(q[W])) ? q[W] + W'(1) : q[W];
      pay[NST-1]   <= pay[NST-2];
    end
  end

  assign out_valid = vld[NST-1];
  assign out_pay   = pay[NST-1];

endmodule

@@ rtl/stick_radial_deadzone_correction.sv @@
// Top level of the stick radial dead zone: config registers, axis normalize, radius,
// dead zone rescale and output register. Uses srdc_pkg, srdc_div and srdc_sqrt.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   input    | in_valid / in_stall     | raw_x, raw_y
//   output   | out_valid / out_stall   | out_x, out_y
//   config   | psel, penable, pready   | paddr, pwdata, prdata
//
// One transfer per cycle sustained while out_stall is low; the path runs through three
// bit-per-stage divider pipelines, the bit-per-stage root pipeline and the output register.
// Synchronous reset clears valid bits and the configuration registers to zero.
// A stall holds only occupied stages; bubbles inside the pipe close up.
module stick_radial_deadzone_correction #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_BITS-1:0]  raw_x,
  input  logic signed [SAMPLE_BITS-1:0]  raw_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_BITS-1:0]  out_x,
  output logic signed [SAMPLE_BITS-1:0]  out_y,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [srdc_pkg::ADDR_W-1:0]    paddr,
  input  logic [srdc_pkg::DATA_W-1:0]    pwdata,
  output logic [srdc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  import srdc_pkg::*;

  localparam int S   = SAMPLE_BITS;
  localparam int CLW = ((S > CENTER_W) ? S : CENTER_W) + 2;
  localparam logic [S-1:0] FULL = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};
  localparam logic signed [CLW-1:0] CMAX = $signed(CLW'(FULL - S'(1)));
  localparam logic signed [CLW-1:0] CMIN = -CMAX;
  localparam int TPW = 3 * S + 3;

  // ---------------- configuration ----------------
  logic signed [CENTER_W-1:0] rest_x;
  logic signed [CENTER_W-1:0] rest_y;
  logic [DZ_W-1:0]            dead_zone;
  logic                       wr;
  reg_idx_t                   idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_x    <= '0;
      rest_y    <= '0;
      dead_zone <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_REST_X:    rest_x    <= pwdata[CENTER_W-1:0];
        REG_REST_Y:    rest_y    <= pwdata[CENTER_W-1:0];
        REG_DEAD_ZONE: dead_zone <= pwdata[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_REST_X:    prdata = DATA_W'(rest_x);
      REG_REST_Y:    prdata = DATA_W'(rest_y);
      REG_DEAD_ZONE: prdata = DATA_W'(dead_zone);
      default:       prdata = '0;
    endcase
  end

  // clamped working copies
  logic signed [CLW-1:0] cw   [2];
  logic signed [CLW-1:0] cc   [2];
  logic signed [S-1:0]   cen  [2];
  logic [CLW-1:0]        dz_w;
  logic [S-1:0]          dz;

  assign cw[0] = CLW'(rest_x);
  assign cw[1] = CLW'(rest_y);
  for (genvar l = 0; l < 2; l++) begin : g_cen
    assign cc[l]  = (cw[l] > CMAX) ? CMAX : ((cw[l] < CMIN) ? CMIN : cw[l]);
    assign cen[l] = $signed(cc[l][S-1:0]);
  end
  assign dz_w = CLW'(dead_zone);
  assign dz   = (dz_w > CLW'(FULL - S'(1))) ? FULL - S'(1) : dz_w[S-1:0];

  // ---------------- front: saturate, center, side scale ----------------
  logic signed [S-1:0]   smp  [2];
  logic signed [S:0]     ofs  [2];
  logic [S:0]            ofs_mag [2];
  logic signed [S+1:0]   dw   [2];
  logic [1:0]            nneg;
  logic [1:0][2*S-1:0]   nn;
  logic [1:0][S-1:0]     nd;

  assign smp[0] = (raw_x == SMIN) ? SMIN + S'(1) : raw_x;
  assign smp[1] = (raw_y == SMIN) ? SMIN + S'(1) : raw_y;

  for (genvar l = 0; l < 2; l++) begin : g_front
    assign ofs[l]     = (S+1)'(smp[l]) - (S+1)'(cen[l]);
    assign nneg[l]    = ofs[l][S];
    assign ofs_mag[l] = nneg[l] ? -ofs[l] : ofs[l];
    assign dw[l]      = (smp[l] >= cen[l]) ? $signed((S+2)'(FULL)) - (S+2)'(cen[l])
                                           : $signed((S+2)'(FULL)) + (S+2)'(cen[l]);
    assign nd[l]      = dw[l][S-1:0];
    assign nn[l]      = (2*S)'(ofs_mag[l][S-1:0]) * (2*S)'(FULL) + (2*S)'(nd[l] >> 1);
  end

  // ---------------- normalize divide ----------------
  logic                n_valid, n_stall;
  logic [1:0][S-1:0]   nq;
  logic [1:0]          n_neg;

  srdc_div #(.LANES(2), .NW(2*S), .DW(S), .QW(S), .PW(2)) u_norm (
    .clk, .rst,
    .in_valid (in_valid),
    .in_stall (in_stall),
    .num      (nn),
    .den      (nd),
    .in_pay   (nneg),
    .out_valid(n_valid),
    .out_stall(n_stall),
    .quo      (nq),
    .out_pay  (n_neg)
  );

  // ---------------- radius ----------------
  logic              r_valid, r_stall;
  logic [S-1:0]      r;
  logic [2*S+1:0]    r_pay;

  srdc_sqrt #(.W(S), .PW(2*S+2)) u_radius (
    .clk, .rst,
    .in_valid (n_valid),
    .in_stall (n_stall),
    .ax       (nq[0]),
    .ay       (nq[1]),
    .in_pay   ({n_neg, nq}),
    .out_valid(r_valid),
    .out_stall(r_stall),
    .r        (r),
    .out_pay  (r_pay)
  );

  // ---------------- dead zone rescale factor ----------------
  logic [S-1:0]        rm, diff, dt;
  logic                hit;
  logic [0:0][2*S-1:0] tn;
  logic [0:0][S-1:0]   td;

  assign rm    = (r < FULL) ? r : FULL;
  assign hit   = (r != '0) && (r > dz);
  assign diff  = hit ? rm - dz : '0;
  assign dt    = FULL - dz;
  assign tn[0] = (2*S)'(diff) * (2*S)'(FULL) + (2*S)'(dt >> 1);
  assign td[0] = dt;

  logic              t_valid, t_stall;
  logic [0:0][S-1:0] tq;
  logic [TPW-1:0]    t_pay;

  srdc_div #(.LANES(1), .NW(2*S), .DW(S), .QW(S), .PW(TPW)) u_factor (
    .clk, .rst,
    .in_valid (r_valid),
    .in_stall (r_stall),
    .num      (tn),
    .den      (td),
    .in_pay   ({r_pay, r, hit}),
    .out_valid(t_valid),
    .out_stall(t_stall),
    .quo      (tq),
    .out_pay  (t_pay)
  );

  // ---------------- per axis scale ----------------
  logic              t_hit;
  logic [S-1:0]      t_r;
  logic [1:0]        t_neg;
  logic [1:0][2*S-1:0] sn;
  logic [1:0][S-1:0]   sd;

  assign t_hit = t_pay[0];
  assign t_r   = t_pay[S:1];
  assign t_neg = t_pay[3*S+2:3*S+1];

  for (genvar l = 0; l < 2; l++) begin : g_scale
    assign sn[l] = (2*S)'(t_pay[S+1+l*S +: S]) * (2*S)'(tq[0]) + (2*S)'(t_r >> 1);
    assign sd[l] = t_hit ? t_r : S'(1);
  end

  logic              c_valid, c_stall;
  logic [1:0][S-1:0] cq;
  logic [2:0]        c_pay;

  srdc_div #(.LANES(2), .NW(2*S), .DW(S), .QW(S), .PW(3)) u_scale (
    .clk, .rst,
    .in_valid (t_valid),
    .in_stall (t_stall),
    .num      (sn),
    .den      (sd),
    .in_pay   ({t_neg, t_hit}),
    .out_valid(c_valid),
    .out_stall(c_stall),
    .quo      (cq),
    .out_pay  (c_pay)
  );

  // ---------------- output register ----------------
  logic [S-1:0] omag [2];
  logic [S-1:0] oval [2];

  for (genvar l = 0; l < 2; l++) begin : g_out
    assign omag[l] = (cq[l] > FULL) ? FULL : cq[l];
    assign oval[l] = !c_pay[0] ? '0 : (c_pay[1+l] ? -omag[l] : omag[l]);
  end

  assign c_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!c_stall) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!c_stall && c_valid) begin
      out_x <= $signed(oval[0]);
      out_y <= $signed(oval[1]);
    end
  end

endmodule

@@ tb/stick_radial_deadzone_correction_tb.sv @@
// Self-checking bench for stick_radial_deadzone_correction: APB register setup,
// random/directed stick samples, integer predictor of the radial dead zone. Uses srdc_pkg.
module stick_radial_deadzone_correction_tb;
  import srdc_pkg::*;

  localparam int SB = 16;
  localparam longint FS = (64'sd1 <<< (SB - 1)) - 1;
  localparam int LAT = 4 * SB + 6;

  typedef struct packed {
    logic signed [SB-1:0] x;
    logic signed [SB-1:0] y;
  } stick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic signed [SB-1:0] raw_x = '0, raw_y = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [SB-1:0] out_x, out_y;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  stick_radial_deadzone_correction #(.SAMPLE_BITS(SB)) u_dut (.*);

  stick_t sample_q[$];
  stick_t corrected_q[$];
  longint cfg_cx = 0, cfg_cy = 0, cfg_dz = 0;
  int errors = 0;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int hold_cycles = 0;
  bit hold_go = 1'b0, hold_done = 1'b0;
  bit in_taken = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint rdiv(longint n, longint d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint isqrt_rnd(longint s);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r = r + (((r + 1) * (r + 1) <= s) ? 1 : 0);
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic longint norm_axis(longint v, longint c);
    longint a, m, d, q;
    a = v - c;
    m = a < 0 ? -a : a;
    d = v >= c ? FS - c : FS + c;
    q = rdiv(m * FS, d);
    return a < 0 ? -q : q;
  endfunction

  function automatic longint scale_axis(longint n, longint t, longint r);
    longint m, q;
    m = n < 0 ? -n : n;
    q = rdiv(m * t, r);
    if (q > FS) q = FS;
    return n < 0 ? -q : q;
  endfunction

  function automatic stick_t correct(stick_t s);
    longint x, y, cx, cy, dz, nx, ny, r, m, t;
    stick_t o;
    x = sat(s.x, -FS, FS);
    y = sat(s.y, -FS, FS);
    cx = sat(cfg_cx, -(FS - 1), FS - 1);
    cy = sat(cfg_cy, -(FS - 1), FS - 1);
    dz = sat(cfg_dz, 0, FS - 1);
    nx = norm_axis(x, cx);
    ny = norm_axis(y, cy);
    r = isqrt_rnd(nx * nx + ny * ny);
    o = '0;
    if (r != 0 && r > dz) begin
      m = r < FS ? r : FS;
      t = rdiv((m - dz) * FS, FS - dz);
      o.x = scale_axis(nx, t, r);
      o.y = scale_axis(ny, t, r);
    end
    return o;
  endfunction

  task automatic write_reg(reg_idx_t idx, longint value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(4 * idx); pwdata <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_REST_X: cfg_cx = longint'($signed(value[CENTER_W-1:0]));
      REG_REST_Y: cfg_cy = longint'($signed(value[CENTER_W-1:0]));
      REG_DEAD_ZONE: cfg_dz = longint'(value[DZ_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || corrected_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic add(longint x, longint y);
    stick_t s;
    s.x = SB'(x);
    s.y = SB'(y);
    sample_q.push_back(s);
  endtask

  task automatic add_random(int n);
    longint lim;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: add($urandom, $urandom);
        1: begin
          lim = (cfg_dz < 2000 ? 2000 : cfg_dz) + 500;
          add(cfg_cx + $urandom_range(0, 2 * lim) - lim,
              cfg_cy + $urandom_range(0, 2 * lim) - lim);
        end
        2: add($urandom_range(0, 1) ? 32767 - $urandom_range(0, 50) : -32768 + $urandom_range(0, 50),
               $urandom);
        default: add($signed(16'($urandom)) >>> $urandom_range(0, 3),
                     $signed(16'($urandom)) >>> $urandom_range(0, 3));
      endcase
    end
  endtask

  // input transfer seen at the rising edge
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_valid) begin
        corrected_q.push_back(correct({raw_x, raw_y}));
      end
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        stick_t s;
        s = sample_q.pop_front();
        in_valid <= 1'b1;
        raw_x <= s.x;
        raw_y <= s.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // stall driver, random or held after hold_go; predictions enqueue at the negedge after a transfer
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      if (hold_cycles == 3 * LAT) hold_done <= 1'b1;
      else hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (corrected_q.size() == 0) begin
        $display("%0t: result with no expectation: x=%0d y=%0d", $time, out_x, out_y);
        errors++;
      end else begin
        stick_t e;
        e = corrected_q.pop_front();
        if (e.x !== out_x) begin
          $display("%0t: out_x mismatch: expected %0d actual %0d", $time, e.x, out_x);
          errors++;
        end
        if (e.y !== out_y) begin
          $display("%0t: out_y mismatch: expected %0d actual %0d", $time, e.y, out_y);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_reg(REG_REST_X, 0);
    write_reg(REG_REST_Y, 0);
    write_reg(REG_DEAD_ZONE, 0);
    add(0, 0); add(-32768, -32768); add(32767, 32767); add(-32768, 32767);
    add(32767, 0); add(0, -32767); add(1, 0); add(-1, -1); add(16'h5555, 16'haaaa);
    drain();
    write_reg(REG_REST_X, 13107);
    write_reg(REG_REST_Y, -13107);
    write_reg(REG_DEAD_ZONE, 13107);
    add(13107, -13107); add(13200, -13000); add(32767, -32768); add(-32768, 32767);
    add(20000, -13107); add(0, 0); add(13107 + 2000, -13107 - 100);
    drain();
    write_reg(REG_REST_X, 16'h4000);
    write_reg(REG_REST_Y, 16'h3fff);
    write_reg(REG_DEAD_ZONE, 16'h3fff);
    add(-16384, 16383); add(32767, -32768); add(-32768, 32767); add(0, 0);
    drain();
    tx_idle_pct = 11; rx_idle_pct = 50;
    write_reg(REG_REST_X, -13107);
    write_reg(REG_REST_Y, 13107);
    write_reg(REG_DEAD_ZONE, 3000);
    add_random(300);
    drain();
    tx_idle_pct = 50; rx_idle_pct = 11;
    write_reg(REG_REST_X, $urandom_range(0, 26214) - 13107);
    write_reg(REG_REST_Y, $urandom_range(0, 26214) - 13107);
    write_reg(REG_DEAD_ZONE, $urandom_range(0, 13107));
    add_random(300);
    drain();
    tx_idle_pct = 0; rx_idle_pct = 0;
    write_reg(REG_REST_X, $urandom_range(0, 26214) - 13107);
    write_reg(REG_REST_Y, $urandom_range(0, 26214) - 13107);
    write_reg(REG_DEAD_ZONE, $urandom_range(0, 1000));
    hold_go = 1'b1;
    add_random(350);
    drain();
    if (errors == 0) $display("stick_radial_deadzone_correction regression: pass");
    else $display("stick_radial_deadzone_correction regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("stick_radial_deadzone_correction regression: fail");
    $finish;
  end

endmodule
